// ----- rtl/mpfe_pkg.sv -----
`timescale 1ns / 1ps

package mpfe_pkg;

    localparam int POS_W   = 24;
    localparam int COUNT_W = 16;
    localparam int BYTE_W  = 8;

    localparam int FRAME_LEN = 13;
    localparam int IDX_W     = $clog2(FRAME_LEN);

    localparam logic [BYTE_W-1:0] SYNC0        = 8'h7E;
    localparam logic [BYTE_W-1:0] SYNC1        = 8'hE7;
    localparam logic [BYTE_W-1:0] CMD_POSITION = 8'h01;

    localparam logic [IDX_W-1:0] IDX_SYNC0 = 4'd0;
    localparam logic [IDX_W-1:0] IDX_SYNC1 = 4'd1;
    localparam logic [IDX_W-1:0] IDX_CMD   = 4'd2;
    localparam logic [IDX_W-1:0] IDX_XH    = 4'd3;
    localparam logic [IDX_W-1:0] IDX_XL    = 4'd4;
    localparam logic [IDX_W-1:0] IDX_YH    = 4'd5;
    localparam logic [IDX_W-1:0] IDX_YL    = 4'd6;
    localparam logic [IDX_W-1:0] IDX_CS    = 4'd12;

    localparam logic REG_MAX_POSITION = 1'b0;
    localparam logic REG_MIN_POSITION = 1'b1;

    localparam logic signed [POS_W-1:0] MAX_POSITION_RESET = 24'sd386560;
    localparam logic signed [POS_W-1:0] MIN_POSITION_RESET = -24'sd386560;

    localparam int QUEUE_DEPTH = 2;

    typedef struct packed {
        logic [COUNT_W-1:0] cy;
        logic [COUNT_W-1:0] cx;
    } counts_t;

endpackage

// ----- rtl/mpfe_queue.sv -----
`timescale 1ns / 1ps

module mpfe_queue #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 2
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             in_valid,
    output logic             in_ready,
    input  logic [WIDTH-1:0] in_data,
    output logic             out_valid,
    input  logic             out_ready,
    output logic [WIDTH-1:0] out_data
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] slot_reg [DEPTH];
    logic [PW-1:0]    wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0]    rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0]    count_reg, count_next;
    logic             push, pop;

    assign in_ready  = (count_reg != CW'(DEPTH));
    assign out_valid = (count_reg != '0);
    assign out_data  = slot_reg[rd_ptr_reg];
    assign push      = in_valid && in_ready;
    assign pop       = out_valid && out_ready;

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == PW'(DEPTH - 1)) ? '0 : wr_ptr_reg + PW'(1);
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == PW'(DEPTH - 1)) ? '0 : rd_ptr_reg + PW'(1);
        end
        if (push && !pop) begin
            count_next = count_reg + CW'(1);
        end else if (pop && !push) begin
            count_next = count_reg - CW'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            slot_reg[wr_ptr_reg] <= in_data;
        end
    end

endmodule

// ----- rtl/mpfe_front.sv -----
`timescale 1ns / 1ps

module mpfe_front (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   cfg_we,
    input  logic                   cfg_addr,
    input  logic [23:0]            cfg_wdata,
    input  logic                   s_tvalid,
    output logic                   s_tready,
    input  logic [47:0]            s_tdata,
    output logic                   push_valid,
    input  logic                   push_ready,
    output mpfe_pkg::counts_t      push_data
);

    logic signed [mpfe_pkg::POS_W-1:0] max_pos_reg, min_pos_reg;
    logic signed [mpfe_pkg::POS_W-1:0] pos_x, pos_y;
    logic signed [mpfe_pkg::POS_W-1:0] clamp_x_next, clamp_y_next;
    logic signed [mpfe_pkg::POS_W-1:0] clamp_x_reg, clamp_y_reg;
    logic                              v1_reg, v2_reg;
    logic                              ready1, ready2;
    mpfe_pkg::counts_t                 counts_next, counts_reg;

    function automatic logic signed [mpfe_pkg::POS_W-1:0] clamp(
        input logic signed [mpfe_pkg::POS_W-1:0] p,
        input logic signed [mpfe_pkg::POS_W-1:0] hi,
        input logic signed [mpfe_pkg::POS_W-1:0] lo
    );
        logic signed [mpfe_pkg::POS_W-1:0] t;
        t = (p > hi) ? hi : p;
        t = (t < lo) ? lo : t;
        return t;
    endfunction

    // Counts of 0.05 are raw * 5 / 64, rounded half away from zero and saturated.
    function automatic logic [mpfe_pkg::COUNT_W-1:0] to_counts(
        input logic signed [mpfe_pkg::POS_W-1:0] p
    );
        logic signed [26:0] n;
        logic [25:0]        mag;
        logic [26:0]        rounded;
        logic [20:0]        q;
        logic [20:0]        neg_q;
        logic [mpfe_pkg::COUNT_W-1:0] res;
        n       = (27'(p) <<< 2) + 27'(p);
        mag     = n[26] ? 26'(-n) : n[25:0];
        rounded = {1'b0, mag} + 27'd32;
        q       = rounded[26:6];
        neg_q   = 21'd0 - q;
        if (n[26]) begin
            res = (q > 21'd32768) ? 16'h8000 : neg_q[15:0];
        end else begin
            res = (q > 21'd32767) ? 16'h7FFF : q[15:0];
        end
        return res;
    endfunction

    assign pos_x = s_tdata[23:0];
    assign pos_y = s_tdata[47:24];

    assign ready2     = !v2_reg || push_ready;
    assign ready1     = !v1_reg || ready2;
    assign s_tready   = ready1;
    assign push_valid = v2_reg;
    assign push_data  = counts_reg;

    assign clamp_x_next = clamp(pos_x, max_pos_reg, min_pos_reg);
    assign clamp_y_next = clamp(pos_y, max_pos_reg, min_pos_reg);

    always_comb begin
        counts_next.cx = to_counts(clamp_x_reg);
        counts_next.cy = to_counts(clamp_y_reg);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            max_pos_reg <= mpfe_pkg::MAX_POSITION_RESET;
            min_pos_reg <= mpfe_pkg::MIN_POSITION_RESET;
        end else if (cfg_we) begin
            case (cfg_addr)
                mpfe_pkg::REG_MAX_POSITION: max_pos_reg <= cfg_wdata;
                mpfe_pkg::REG_MIN_POSITION: min_pos_reg <= cfg_wdata;
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
        end else begin
            if (ready1) begin
                v1_reg <= s_tvalid;
            end
            if (ready2) begin
                v2_reg <= v1_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (ready1) begin
            clamp_x_reg <= clamp_x_next;
            clamp_y_reg <= clamp_y_next;
        end
        if (ready2) begin
            counts_reg <= counts_next;
        end
    end

endmodule

// ----- rtl/mpfe_back.sv -----
`timescale 1ns / 1ps

module mpfe_back (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              frame_valid,
    output logic              frame_pop,
    input  mpfe_pkg::counts_t frame_data,
    output logic              m_tvalid,
    input  logic              m_tready,
    output logic [7:0]        m_tdata,
    output logic              m_tlast
);

    logic [mpfe_pkg::IDX_W-1:0]  idx_reg, idx_next;
    logic                        m_tvalid_reg;
    logic [mpfe_pkg::BYTE_W-1:0] m_tdata_reg, byte_next;
    logic                        m_tlast_reg;
    logic                        out_load, emit, is_last;
    logic [mpfe_pkg::BYTE_W-1:0] checksum;

    assign out_load  = !m_tvalid_reg || m_tready;
    assign emit      = out_load && frame_valid;
    assign is_last   = (idx_reg == mpfe_pkg::IDX_CS);
    assign frame_pop = emit && is_last;
    assign idx_next  = is_last ? '0 : idx_reg + mpfe_pkg::IDX_W'(1);

    assign checksum = ~(mpfe_pkg::CMD_POSITION + frame_data.cx[15:8] + frame_data.cx[7:0]
                        + frame_data.cy[15:8] + frame_data.cy[7:0]);

    always_comb begin
        case (idx_reg)
            mpfe_pkg::IDX_SYNC0: byte_next = mpfe_pkg::SYNC0;
            mpfe_pkg::IDX_SYNC1: byte_next = mpfe_pkg::SYNC1;
            mpfe_pkg::IDX_CMD:   byte_next = mpfe_pkg::CMD_POSITION;
            mpfe_pkg::IDX_XH:    byte_next = frame_data.cx[15:8];
            mpfe_pkg::IDX_XL:    byte_next = frame_data.cx[7:0];
            mpfe_pkg::IDX_YH:    byte_next = frame_data.cy[15:8];
            mpfe_pkg::IDX_YL:    byte_next = frame_data.cy[7:0];
            mpfe_pkg::IDX_CS:    byte_next = checksum;
            default:             byte_next = '0;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            idx_reg      <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            if (out_load) begin
                m_tvalid_reg <= frame_valid;
            end
            if (emit) begin
                idx_reg <= idx_next;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (emit) begin
            m_tdata_reg <= byte_next;
            m_tlast_reg <= is_last;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tlast  = m_tlast_reg;

endmodule

// ----- rtl/mirror_position_frame_encoder.sv -----
`timescale 1ns / 1ps

// Mirror position frame encoder.
// Each request on the slave stream carries an X and a Y position, signed with
// 8 fractional bits. Both are clamped to max_position and then min_position,
// converted to counts of 0.05 and sent as a 13-byte command frame on the
// master stream, one byte per beat, with tlast on the trailing checksum byte.
// The clamp limits are written through the cfg_we/cfg_addr/cfg_wdata port;
// the user must write them only while the block is idle, as the block does
// not enforce this; index 0 is max_position and index 1 is min_position.
// The first byte of a frame passes the clamp, counts, queue and output
// registers in turn, then the output sends one byte per cycle while m_tready
// is high. A two-stage front pipeline and a small queue keep accepting
// requests while a frame is sent. A synchronous active-low reset empties the
// pipeline, the queue and the output register and restores the limits to
// +1510.0 and -1510.0. When the receiver stalls, the current byte holds on
// m_tdata, the queue fills and s_tready then falls until room opens up again.
module mirror_position_frame_encoder #(
    parameter int QUEUE_DEPTH = mpfe_pkg::QUEUE_DEPTH
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_we,
    input  logic        cfg_addr,
    input  logic [23:0] cfg_wdata,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [47:0] s_tdata,   // pos_x [23:0], pos_y [47:24]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata,   // frame_byte [7:0]
    output logic        m_tlast
);

    logic              push_valid, push_ready;
    mpfe_pkg::counts_t push_data;
    logic              frame_valid, frame_pop;
    mpfe_pkg::counts_t frame_data;

    mpfe_front u_front (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg_we     (cfg_we),
        .cfg_addr   (cfg_addr),
        .cfg_wdata  (cfg_wdata),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_data  (push_data)
    );

    mpfe_queue #(
        .WIDTH ($bits(mpfe_pkg::counts_t)),
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (push_valid),
        .in_ready  (push_ready),
        .in_data   (push_data),
        .out_valid (frame_valid),
        .out_ready (frame_pop),
        .out_data  (frame_data)
    );

    mpfe_back u_back (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .frame_valid (frame_valid),
        .frame_pop   (frame_pop),
        .frame_data  (frame_data),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tlast     (m_tlast)
    );

endmodule

// ----- rtl/mpfe_checker.sv -----
`timescale 1ns / 1ps

module mpfe_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [7:0]  m_tdata,
    input logic        m_tlast
);

    logic [mpfe_pkg::IDX_W-1:0] pos_reg;
    logic                       m_fire;

    assign m_fire = m_tvalid && m_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_reg <= '0;
        end else if (m_fire) begin
            pos_reg <= (pos_reg == mpfe_pkg::IDX_CS) ? '0 : pos_reg + mpfe_pkg::IDX_W'(1);
        end
    end

    // Every frame is exactly thirteen bytes long and closes with tlast.
    a_last_position: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tlast == (pos_reg == mpfe_pkg::IDX_CS)))
        else $error("tlast does not fall on the thirteenth byte");

    a_sync_head: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && pos_reg == mpfe_pkg::IDX_SYNC0) |-> (m_tdata == mpfe_pkg::SYNC0))
        else $error("frame does not start with the first sync byte");

    a_header: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_fire && pos_reg == mpfe_pkg::IDX_SYNC0) |=>
            (!m_tvalid || (m_tdata == mpfe_pkg::SYNC1 && !m_tlast)))
        else $error("second sync byte missing");

    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata) && $stable(m_tlast)))
        else $error("stalled output byte changed");

    a_reset_idle: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("output valid right after reset");

endmodule

bind mirror_position_frame_encoder mpfe_checker u_checker (.*);
